[rtl/tpa_pkg.sv]
package tpa_pkg;

	localparam int CHANNELS     = 8;
	localparam int SAMPLES      = 2048;
	localparam int TEMPLATE_LEN = 1024;

	localparam int CMD_W    = 2;
	localparam int CH_W     = 3;
	localparam int POS_W    = 11;
	localparam int CNT_W    = 8;
	localparam int TV_W     = 16;
	localparam int ADC_W    = 16;
	localparam int SAMPLE_W = 24;
	localparam int FRAME_W  = 12;
	localparam int TLEN_W   = 11;

	localparam int SAMP_AW    = $clog2(SAMPLES);
	localparam int TMPL_AW    = $clog2(TEMPLATE_LEN);
	localparam int WAVE_AW    = CH_W + SAMP_AW;
	localparam int WAVE_DEPTH = 2 ** WAVE_AW;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
	localparam logic [SAMPLE_W:0]   HALF_LSB   = (SAMPLE_W+1)'(128);

	localparam logic [PADDR_W-3:0] REG_FRAME_LENGTH    = 1'b0;
	localparam logic [PADDR_W-3:0] REG_TEMPLATE_LENGTH = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [CH_W-1:0]  channel;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] photon_count;
		logic [TV_W-1:0]  template_value;
	} item_t;

	typedef struct packed {
		logic [ADC_W-1:0] adc_value;
		logic [CH_W-1:0]  out_channel;
		logic [POS_W-1:0] out_index;
		logic             saturated;
	} result_t;

	typedef struct packed {
		logic                valid;
		logic [WAVE_AW-1:0]  addr;
		logic [CNT_W-1:0]    count;
		logic [TV_W-1:0]     tmpl;
		logic [SAMPLE_W-1:0] wave;
	} mac_in_t;

	typedef struct packed {
		logic                en;
		logic [WAVE_AW-1:0]  addr;
		logic [SAMPLE_W-1:0] data;
	} wave_wr_t;

endpackage

[rtl/template_pulse_accumulator.sv]
// Adds scaled copies of a single-photoelectron pulse template into eight channel waveform
// memories of 2048 Q16.8 samples and reads samples back rounded and saturated to 16 bits,
// clearing each one as it is read. After reset the waveform memory is cleared one sample a
// cycle, all 16384 samples, during which item_stall stays high; configuration writes are taken.
// A load leaves item_stall low, and a read holds it high until the result register can take the
// sample. An add covers n samples, n = min(template_length, frame_length - position), with the
// lengths capped at 1024 and 2048 and n zero past the frame end: the waveform memory does one
// read-modify-write per cycle through a two-stage multiply and saturating add, and the pipeline
// drains before the next transfer.
module template_pulse_accumulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpa_pkg::PADDR_W-1:0]  paddr,
	input  logic [tpa_pkg::PDATA_W-1:0]  pwdata,
	output logic [tpa_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  tpa_pkg::item_t               item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output tpa_pkg::result_t             result
);
	import tpa_pkg::*;

	state_t state_q, state_d;

	logic [FRAME_W-1:0]  frame_length_q;
	logic [TLEN_W-1:0]   template_length_q;
	logic [FRAME_W-1:0]  frame_use;
	logic [TLEN_W-1:0]   tlen_use;

	logic [WAVE_AW-1:0]  clr_q;
	logic [TLEN_W-1:0]   t_q;
	logic [FRAME_W-1:0]  bin_q;
	logic [FRAME_W-1:0]  frame_lim_q;
	logic [TLEN_W-1:0]   tlen_lim_q;
	logic                rd_ok_q;
	logic [CH_W-1:0]     ch_q;
	logic [CNT_W-1:0]    count_q;
	logic [POS_W-1:0]    pos_q;
	logic [WAVE_AW-1:0]  rd_addr_q;

	logic                valid_s1;
	logic [WAVE_AW-1:0]  addr_s1;

	logic [SAMPLE_W-1:0] wave_mem [WAVE_DEPTH];
	logic [SAMPLE_W-1:0] wave_rd_q;
	logic [TV_W-1:0]     tmpl_mem [TEMPLATE_LEN];
	logic [TV_W-1:0]     tmpl_rd_q;

	logic                accept;
	logic                cfg_wr;
	logic                ch_ok;
	logic                pos_ok;
	logic                issue;
	logic                read_done;
	logic                tmpl_we;
	logic                wave_re;
	logic [WAVE_AW-1:0]  wave_raddr;
	logic [WAVE_AW-1:0]  item_addr;
	logic [WAVE_AW-1:0]  add_addr;
	logic [SAMPLE_W:0]   rounded;
	mac_in_t             mac_in;
	wave_wr_t            mac_wr;
	wave_wr_t            wave_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q    <= FRAME_W'(2048);
			template_length_q <= TLEN_W'(1024);
		end else if (cfg_wr) begin
			case (paddr[PADDR_W-1:2])
				REG_FRAME_LENGTH:    frame_length_q    <= pwdata[FRAME_W-1:0];
				REG_TEMPLATE_LENGTH: template_length_q <= pwdata[TLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[PADDR_W-1:2])
			REG_FRAME_LENGTH:    prdata = PDATA_W'(frame_length_q);
			REG_TEMPLATE_LENGTH: prdata = PDATA_W'(template_length_q);
			default:             prdata = '0;
		endcase
	end

	assign frame_use = (frame_length_q > FRAME_W'(SAMPLES)) ? FRAME_W'(SAMPLES) : frame_length_q;
	assign tlen_use  = (template_length_q > TLEN_W'(TEMPLATE_LEN)) ?
	                   TLEN_W'(TEMPLATE_LEN) : template_length_q;

	// item decode
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid & ~item_stall;
	assign ch_ok      = {1'b0, item.channel} < (CH_W+1)'(CHANNELS);
	assign pos_ok     = FRAME_W'(item.position) < frame_use;
	assign item_addr  = {item.channel, item.position[SAMP_AW-1:0]};
	assign tmpl_we    = accept && (item.cmd == CMD_LOAD) &&
	                    ({1'b0, item.position} < (POS_W+1)'(TEMPLATE_LEN));

	assign issue     = (state_q == ST_ADD) && (t_q < tlen_lim_q) && (bin_q < frame_lim_q);
	assign add_addr  = {ch_q, bin_q[SAMP_AW-1:0]};
	assign read_done = (state_q == ST_READ) && (!result_valid || !result_stall);

	assign wave_re    = issue || (accept && (item.cmd == CMD_READ));
	assign wave_raddr = issue ? add_addr : item_addr;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wave_wr.en   = 1'b1;
			wave_wr.addr = clr_q;
			wave_wr.data = '0;
		end else if (read_done) begin
			wave_wr.en   = rd_ok_q;
			wave_wr.addr = rd_addr_q;
			wave_wr.data = '0;
		end else begin
			wave_wr = mac_wr;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (wave_wr.en) begin
			wave_mem[wave_wr.addr] <= wave_wr.data;
		end
		if (wave_re) begin
			wave_rd_q <= wave_mem[wave_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tmpl_we) begin
			tmpl_mem[item.position[TMPL_AW-1:0]] <= item.template_value;
		end
		if (issue) begin
			tmpl_rd_q <= tmpl_mem[t_q[TMPL_AW-1:0]];
		end
	end

	// read-modify-write pipeline
	always_comb begin
		mac_in.valid = valid_s1;
		mac_in.addr  = addr_s1;
		mac_in.count = count_q;
		mac_in.tmpl  = tmpl_rd_q;
		mac_in.wave  = wave_rd_q;
	end

	tpa_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.mac_in (mac_in),
		.wr     (mac_wr)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (item.cmd)
						CMD_ADD:  state_d = ST_ADD;
						CMD_READ: state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (!issue && !valid_s1 && !mac_wr.en) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (read_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			t_q         <= '0;
			bin_q       <= '0;
			frame_lim_q <= '0;
			tlen_lim_q  <= '0;
			rd_ok_q     <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				t_q         <= '0;
				bin_q       <= FRAME_W'(item.position);
				frame_lim_q <= frame_use;
				tlen_lim_q  <= ch_ok ? tlen_use : '0;
				rd_ok_q     <= ch_ok && pos_ok;
			end else if (issue) begin
				t_q   <= t_q + 1'b1;
				bin_q <= bin_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= item.channel;
			count_q   <= item.photon_count;
			pos_q     <= item.position;
			rd_addr_q <= item_addr;
		end
		if (issue) begin
			addr_s1 <= add_addr;
		end
	end

	// result register
	assign rounded = (SAMPLE_W+1)'(wave_rd_q) + HALF_LSB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (read_done) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_done) begin
			result.out_channel <= ch_q;
			result.out_index   <= pos_q;
			if (!rd_ok_q) begin
				result.adc_value <= '0;
				result.saturated <= 1'b0;
			end else if (rounded[SAMPLE_W]) begin
				result.adc_value <= '1;
				result.saturated <= 1'b1;
			end else begin
				result.adc_value <= rounded[SAMPLE_W-1:8];
				result.saturated <= 1'b0;
			end
		end
	end

endmodule

[rtl/tpa_mac.sv]
module tpa_mac (
	input  logic             clk,
	input  logic             arst_n,
	input  tpa_pkg::mac_in_t mac_in,
	output tpa_pkg::wave_wr_t wr
);
	import tpa_pkg::*;

	logic                          valid_s2;
	logic [WAVE_AW-1:0]            addr_s2;
	logic [CNT_W+TV_W-1:0]         prod_s2;
	logic [SAMPLE_W-1:0]           wave_s2;
	logic [SAMPLE_W:0]             sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= mac_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= mac_in.addr;
		prod_s2 <= (CNT_W+TV_W)'(mac_in.count) * (CNT_W+TV_W)'(mac_in.tmpl);
		wave_s2 <= mac_in.wave;
	end

	assign sum = (SAMPLE_W+1)'(wave_s2) + (SAMPLE_W+1)'(prod_s2);

	always_comb begin
		wr.en   = valid_s2;
		wr.addr = addr_s2;
		wr.data = sum[SAMPLE_W] ? SAMPLE_MAX : sum[SAMPLE_W-1:0];
	end

endmodule

[rtl/tpa_checker.sv]
module tpa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [tpa_pkg::PADDR_W-1:0]  paddr,
	input logic [tpa_pkg::PDATA_W-1:0]  pwdata,
	input logic [tpa_pkg::PDATA_W-1:0]  prdata,
	input logic                         pready,
	input logic                         item_valid,
	input logic                         item_stall,
	input tpa_pkg::item_t               item,
	input logic                         result_valid,
	input logic                         result_stall,
	input tpa_pkg::result_t             result
);
	import tpa_pkg::*;

	logic read_xfer_free;

	assign read_xfer_free = item_valid && !item_stall && (item.cmd == CMD_READ) &&
	                        !result_valid;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		read_xfer_free |=> ##1 result_valid)
		else $error("read result late");

	a_read_index: assert property (@(posedge clk) disable iff (!arst_n)
		read_xfer_free |=> ##1 (result.out_index == $past(item.position, 2)))
		else $error("read result index mismatch");

endmodule

bind template_pulse_accumulator tpa_checker u_tpa_checker (.*);

[tb/tb_template_pulse_accumulator.sv]
module tb_template_pulse_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	import tpa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ADD_DRAIN_CYCLES = TEMPLATE_LEN + 64;
	localparam int QUIET_LIMIT      = 80000;
	localparam int END_SETTLE       = 64;
	localparam int MAX_REPORTS      = 10;
	// template words loaded up front; adds never reach past them
	localparam int PRELOAD_LEN      = 256;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;

	// shadow of the block state
	bit [SAMPLE_W-1:0] wave_model [WAVE_DEPTH];
	bit [TV_W-1:0]     tmpl_model [TEMPLATE_LEN];
	int unsigned       frame_reg = SAMPLES;
	int unsigned       tlen_reg  = TEMPLATE_LEN;

	result_t           expected_samples [$];
	int                errors       = 0;
	int                quiet_cycles = 0;
	int unsigned       tx_idle_pct  = 0;
	int unsigned       rx_stall_pct = 0;
	logic [CH_W-1:0]   hot_ch  = '0;
	logic [POS_W-1:0]  hot_pos = '0;

	template_pulse_accumulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #6 clk = ~clk;

	function automatic int unsigned frame_in_use();
		return (frame_reg > SAMPLES) ? SAMPLES : frame_reg;
	endfunction

	function automatic int unsigned template_in_use();
		return (tlen_reg > TEMPLATE_LEN) ? TEMPLATE_LEN : tlen_reg;
	endfunction

	function automatic void flag_error(string msg);
		if (errors < MAX_REPORTS) begin
			$display("%s", msg);
		end
		errors++;
	endfunction

	function automatic void accumulate_item(item_t it);
		int unsigned        fr;
		int unsigned        tl;
		int unsigned        bin;
		int unsigned        sum;
		int unsigned        rounded;
		logic [WAVE_AW-1:0] addr;
		result_t            r;
		fr = frame_in_use();
		tl = template_in_use();
		case (it.cmd)
			CMD_LOAD: begin
				if (it.position < TEMPLATE_LEN) begin
					tmpl_model[it.position[TMPL_AW-1:0]] = it.template_value;
				end
			end
			CMD_ADD: begin
				for (int t = 0; t < tl; t++) begin
					bin = it.position + t;
					if (bin >= fr) begin
						break;
					end
					addr = {it.channel, SAMP_AW'(bin)};
					sum = wave_model[addr] + it.photon_count * tmpl_model[TMPL_AW'(t)];
					wave_model[addr] = (sum > SAMPLE_MAX) ? SAMPLE_MAX : SAMPLE_W'(sum);
				end
			end
			CMD_READ: begin
				r = '0;
				r.out_channel = it.channel;
				r.out_index = it.position;
				if (it.position < fr) begin
					addr = {it.channel, it.position};
					rounded = (wave_model[addr] + HALF_LSB) >> 8;
					if (rounded > 32'hFFFF) begin
						r.adc_value = '1;
						r.saturated = 1'b1;
					end else begin
						r.adc_value = ADC_W'(rounded);
					end
					wave_model[addr] = '0;
				end
				expected_samples.insert(expected_samples.size(), r);
			end
			default: ;
		endcase
	endfunction

	function automatic item_t mk_item(logic [CMD_W-1:0] cmd, int unsigned ch, int unsigned pos,
			int unsigned cnt, int unsigned tv);
		item_t it;
		it.cmd = cmd;
		it.channel = CH_W'(ch);
		it.position = POS_W'(pos);
		it.photon_count = CNT_W'(cnt);
		it.template_value = TV_W'(tv);
		return it;
	endfunction

	function automatic logic [TV_W-1:0] tmpl_word();
		case ($urandom_range(3))
			0: return '1;
			1: return TV_W'($urandom_range(255));
			default: return TV_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic void set_idling(int mode);
		case (mode % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
			default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
		endcase
	endfunction

	// mostly adds around a moving hot spot and reads that land on it
	function automatic item_t random_item();
		item_t       it;
		int unsigned fr;
		int unsigned tl;
		int unsigned pick;
		fr = frame_in_use();
		tl = template_in_use();
		it = mk_item(CMD_READ, $urandom_range(CHANNELS - 1), $urandom_range(SAMPLES - 1),
			$urandom_range(255), $urandom_range(16'hFFFF));
		pick = $urandom_range(99);
		if (pick < 5) begin
			it.cmd = CMD_UNUSED;
		end else if (pick < 15) begin
			it.cmd = CMD_LOAD;
			if ($urandom_range(9) != 0) begin
				it.position = POS_W'($urandom_range(TEMPLATE_LEN - 1));
			end
			it.template_value = tmpl_word();
		end else if (pick < 50) begin
			it.cmd = CMD_ADD;
			case ($urandom_range(9))
				0, 1: ;
				2: if (fr > 8) it.position = POS_W'(fr - $urandom_range(1, 8));
				3, 4, 5: begin
					it.channel = hot_ch;
					it.position = hot_pos;
				end
				default: if (fr > 0) it.position = POS_W'($urandom_range(fr - 1));
			endcase
			case ($urandom_range(19))
				0: it.photon_count = '0;
				1, 2, 3, 4, 5, 6: it.photon_count = '1;
				default: it.photon_count = CNT_W'($urandom_range(1, 255));
			endcase
			hot_ch = it.channel;
			hot_pos = it.position;
		end else if ($urandom_range(3) != 0) begin
			it.channel = hot_ch;
			it.position = POS_W'(hot_pos + $urandom_range(tl + 1));
		end
		return it;
	endfunction

	task automatic transfer_item(input item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		accumulate_item(it);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only once the block has drained
	task automatic configure(input int unsigned frame, input int unsigned tlen);
		item_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (ADD_DRAIN_CYCLES) @(posedge clk);
		write_reg({REG_FRAME_LENGTH, 2'b00}, frame);
		frame_reg = frame & ((1 << FRAME_W) - 1);
		write_reg({REG_TEMPLATE_LENGTH, 2'b00}, tlen);
		tlen_reg = tlen & ((1 << TLEN_W) - 1);
	endtask

	task automatic run_random(input int n);
		int    sent;
		item_t it;
		sent = 0;
		while (sent < n) begin
			it = random_item();
			transfer_item(it);
			if (it.cmd != CMD_UNUSED && !(it.cmd == CMD_LOAD && it.position >= TEMPLATE_LEN)) begin
				sent++;
			end
		end
	endtask

	task automatic preload_template();
		for (int i = 0; i < PRELOAD_LEN; i++) begin
			transfer_item(mk_item(CMD_LOAD, $urandom_range(CHANNELS - 1), i,
				$urandom_range(255), tmpl_word()));
		end
	endtask

	task automatic test_basic_operations();
		set_idling(0);
		configure(SAMPLES, 16);
		transfer_item(mk_item(CMD_LOAD, 0, 0, 0, 16'hFFFF));
		transfer_item(mk_item(CMD_LOAD, 7, TEMPLATE_LEN - 1, 255, 0));
		transfer_item(mk_item(CMD_LOAD, 0, TEMPLATE_LEN, 0, 16'h1234));
		transfer_item(mk_item(CMD_LOAD, 7, SAMPLES - 1, 255, 16'hFFFF));
		transfer_item(mk_item(CMD_UNUSED, 7, SAMPLES - 1, 255, 16'hFFFF));
		// two full-scale pulses clip the sum, then rounding overflows 16 bits
		transfer_item(mk_item(CMD_ADD, 7, 0, 255, 0));
		transfer_item(mk_item(CMD_ADD, 7, 0, 255, 0));
		transfer_item(mk_item(CMD_READ, 7, 0, 0, 0));
		transfer_item(mk_item(CMD_READ, 7, 0, 0, 0));
		transfer_item(mk_item(CMD_ADD, 0, SAMPLES - 1, 1, 16'hFFFF));
		transfer_item(mk_item(CMD_READ, 0, SAMPLES - 1, 0, 0));
		transfer_item(mk_item(CMD_ADD, 3, SAMPLES - 8, 1, 0));
		transfer_item(mk_item(CMD_READ, 3, SAMPLES - 1, 0, 0));
		transfer_item(mk_item(CMD_READ, 3, SAMPLES - 8, 0, 0));
		transfer_item(mk_item(CMD_READ, 5, SAMPLES - 1, 0, 0));
	endtask

	task automatic test_frame_edges();
		set_idling(3);
		configure(SAMPLES, 16);
		transfer_item(mk_item(CMD_ADD, 2, 200, 10, 0));
		configure(100, 16);
		// beyond the frame: zero result, sample left intact
		transfer_item(mk_item(CMD_READ, 2, 200, 0, 0));
		transfer_item(mk_item(CMD_READ, 7, SAMPLES - 1, 0, 0));
		transfer_item(mk_item(CMD_ADD, 1, 95, 3, 0));
		transfer_item(mk_item(CMD_READ, 1, 99, 0, 0));
		configure(SAMPLES, 16);
		transfer_item(mk_item(CMD_READ, 1, 100, 0, 0));
		transfer_item(mk_item(CMD_READ, 2, 200, 0, 0));
	endtask

	task automatic test_register_extremes();
		set_idling(2);
		configure(0, 16);
		transfer_item(mk_item(CMD_ADD, 4, 0, 255, 0));
		transfer_item(mk_item(CMD_READ, 4, 0, 0, 0));
		configure(SAMPLES, 0);
		transfer_item(mk_item(CMD_ADD, 4, 0, 255, 0));
		transfer_item(mk_item(CMD_READ, 4, 0, 0, 0));
		configure((1 << FRAME_W) - 1, (1 << TLEN_W) - 1);
		transfer_item(mk_item(CMD_ADD, 6, SAMPLES - 200, 2, 0));
		transfer_item(mk_item(CMD_READ, 6, SAMPLES - 1, 0, 0));
		transfer_item(mk_item(CMD_READ, 6, SAMPLES - 200, 0, 0));
		transfer_item(mk_item(CMD_READ, 6, 0, 0, 0));
	endtask

	task automatic test_random_nominal();
		configure(SAMPLES, 32);
		set_idling(0);
		run_random(60);
	endtask

	task automatic test_random_short_frames();
		configure(64, 1);
		set_idling(1);
		run_random(50);
		configure(1, 16);
		set_idling(2);
		run_random(30);
	endtask

	task automatic test_random_varied_settings();
		for (int k = 0; k < 5; k++) begin
			configure($urandom_range(1, (1 << FRAME_W) - 1), $urandom_range(1, 64));
			set_idling(3 - k);
			run_random(25);
		end
	endtask

	task automatic test_random_full_length();
		configure((1 << FRAME_W) - 1, PRELOAD_LEN);
		set_idling(3);
		run_random(20);
	endtask

	task automatic test_random_zero_registers();
		configure(0, TEMPLATE_LEN);
		set_idling(1);
		run_random(5);
		configure(SAMPLES, 0);
		set_idling(2);
		run_random(5);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_samples.size() == 0) begin
				flag_error($sformatf("unexpected result adc=%0d ch=%0d idx=%0d sat=%0b",
					result.adc_value, result.out_channel, result.out_index, result.saturated));
			end else begin
				want = expected_samples.pop_front();
				if (result.adc_value !== want.adc_value ||
						result.out_channel !== want.out_channel ||
						result.out_index !== want.out_index ||
						result.saturated !== want.saturated) begin
					flag_error($sformatf(
						"mismatch: expected adc=%0d ch=%0d idx=%0d sat=%0b, got adc=%0d ch=%0d idx=%0d sat=%0b",
						want.adc_value, want.out_channel, want.out_index, want.saturated,
						result.adc_value, result.out_channel, result.out_index, result.saturated));
				end
			end
		end
		result_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	// no transfer for too long means the block hung
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** template_pulse_accumulator: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		preload_template();
		test_basic_operations();
		test_frame_edges();
		test_register_extremes();
		test_random_nominal();
		test_random_short_frames();
		test_random_varied_settings();
		test_random_full_length();
		test_random_zero_registers();
		item_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		rx_stall_pct = 0;
		repeat (END_SETTLE) @(posedge clk);
		if (expected_samples.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", expected_samples.size()));
		end
		if (errors == 0) begin
			$display("** template_pulse_accumulator: PASSED **");
		end else begin
			$display("** template_pulse_accumulator: FAILED **");
		end
		$finish;
	end

endmodule

[template_pulse_accumulator.f]
rtl/tpa_pkg.sv
rtl/tpa_mac.sv
rtl/template_pulse_accumulator.sv
rtl/tpa_checker.sv
tb/tb_template_pulse_accumulator.sv
